// ===== sv/plr_pkg.sv =====
// Package for the printer link packet receiver.
// Holds link constants, command codes, status masks and the shared types.
// No dependencies.
`default_nettype none

package plr_pkg;

	// link framing bytes
	localparam logic [7:0] SYNC1_BYTE     = 8'h88;
	localparam logic [7:0] SYNC2_BYTE     = 8'h33;
	localparam logic [7:0] PRINT_END_BYTE = 8'h03;

	// fixed command codes
	localparam logic [7:0] CMD_INIT   = 8'h01;
	localparam logic [7:0] CMD_PRINT  = 8'h02;
	localparam logic [7:0] CMD_DATA   = 8'h04;
	localparam logic [7:0] CMD_BREAK  = 8'h08;
	localparam logic [7:0] CMD_STATUS = 8'h0F;

	// status bits
	localparam logic [7:0] STATUS_BUSY_MASK = 8'h02;
	localparam logic [7:0] STATUS_FULL_MASK = 8'h04;

	// configuration registers
	localparam int unsigned HOLD_W    = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_XFER_OPC   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUSY_HOLD  = 2'd2;
	localparam logic [7:0]        DEVICE_ID_RESET = 8'd129;
	localparam logic [7:0]        XFER_OPC_RESET  = 8'd16;
	localparam logic [HOLD_W-1:0] BUSY_HOLD_RESET = 24'd100000; // busy hold, counted in ticks

	// result kinds
	typedef enum logic [2:0] {
		KIND_REPLY   = 3'd0,
		KIND_CMD     = 3'd1,
		KIND_FWD     = 3'd2,
		KIND_SINK_RST = 3'd3,
		KIND_COMMIT  = 3'd4
	} kind_t;

	// command class
	typedef enum logic [2:0] {
		CL_INIT     = 3'd0,
		CL_PRINT    = 3'd1,
		CL_DATA     = 3'd2,
		CL_BREAK    = 3'd3,
		CL_STATUS   = 3'd4,
		CL_TRANSFER = 3'd5,
		CL_OTHER    = 3'd6
	} cls_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} result_t;

	// up to three results caused by one link byte
	typedef struct packed {
		logic [1:0]        cnt;
		result_t [2:0]     item;
	} bundle_t;

	typedef struct packed {
		logic [7:0]        device_id;
		logic [7:0]        xfer_opc;
		logic [HOLD_W-1:0] busy_hold;
	} cfg_t;

	// fixed codes take priority over the configurable transfer code
	function automatic cls_t classify(input logic [7:0] c, input logic [7:0] xfer);
		cls_t r;
		if (c == CMD_INIT)        r = CL_INIT;
		else if (c == CMD_PRINT)  r = CL_PRINT;
		else if (c == CMD_DATA)   r = CL_DATA;
		else if (c == CMD_BREAK)  r = CL_BREAK;
		else if (c == CMD_STATUS) r = CL_STATUS;
		else if (c == xfer)       r = CL_TRANSFER;
		else                      r = CL_OTHER;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/plr_core.sv =====
// Packet phase machine of the printer link receiver: state registers and
// the per-byte result bundle. Depends on plr_pkg.
`default_nettype none

module plr_core #(
	parameter int unsigned TIMER_BITS = 24
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,      // link byte processed this cycle
	input  wire                 tick,      // timer tick processed this cycle
	input  wire  [7:0]          rx_byte,
	input  plr_pkg::cfg_t       cfg,
	output plr_pkg::bundle_t    bundle
);
	import plr_pkg::*;

	localparam int unsigned CMP_W = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;

	typedef enum logic [10:0] {
		PH_SYNC1  = 11'b000_0000_0001,
		PH_SYNC2  = 11'b000_0000_0010,
		PH_CMD    = 11'b000_0000_0100,
		PH_COMP   = 11'b000_0000_1000,
		PH_LENLO  = 11'b000_0001_0000,
		PH_LENHI  = 11'b000_0010_0000,
		PH_DATA   = 11'b000_0100_0000,
		PH_CK1    = 11'b000_1000_0000,
		PH_CK2    = 11'b001_0000_0000,
		PH_DEVID  = 11'b010_0000_0000,
		PH_STATUS = 11'b100_0000_0000
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [7:0]            cmd_q, cmd_d;
	logic [7:0]            rep_q, rep_d;
	logic [7:0]            pend_q, pend_d;
	logic [15:0]           len_q, len_d;
	logic [15:0]           count_q, count_d;
	logic                  commit_q, commit_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;

	logic [15:0]  len_full;
	logic [15:0]  count_inc;
	cls_t         byte_cls;
	cls_t         cmd_cls;
	logic [1:0]   ev_cnt;
	result_t [2:0] ev;
	logic [7:0]   reply;
	logic         hold_over;

	assign byte_cls  = classify(rx_byte, cfg.xfer_opc);
	assign cmd_cls   = classify(cmd_q, cfg.xfer_opc);
	assign len_full  = {rx_byte, len_q[7:0]};
	assign count_inc = count_q + 16'd1;
	assign hold_over = CMP_W'(timer_q) > CMP_W'(cfg.busy_hold);

	// next state and sink events for one link byte
	always_comb begin
		phase_d  = phase_q;
		cmd_d    = cmd_q;
		rep_d    = rep_q;
		pend_d   = pend_q;
		len_d    = len_q;
		count_d  = count_q;
		commit_d = commit_q;
		ev_cnt   = 2'd0;
		ev       = '0;
		reply    = 8'd0;
		case (phase_q)
			PH_SYNC1: begin
				commit_d = 1'b0;
				phase_d  = (rx_byte == SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;
			end
			PH_SYNC2: begin
				phase_d = (rx_byte == SYNC2_BYTE) ? PH_CMD : PH_SYNC1;
			end
			PH_CMD: begin
				cmd_d   = rx_byte;
				phase_d = PH_COMP;
				rep_d   = pend_q;
				ev[0]   = '{kind: KIND_CMD, value: rx_byte, last: 1'b0};
				ev_cnt  = 2'd1;
				case (byte_cls)
					CL_INIT: begin
						rep_d  = 8'd0;
						pend_d = 8'd0;
						ev[1]  = '{kind: KIND_FWD, value: rx_byte, last: 1'b0};
						ev_cnt = 2'd2;
					end
					CL_PRINT: begin
						if ((pend_q & STATUS_FULL_MASK) != 8'd0)
							pend_d = pend_q | STATUS_BUSY_MASK;
						ev[1]  = '{kind: KIND_FWD, value: rx_byte, last: 1'b0};
						ev_cnt = 2'd2;
					end
					CL_DATA, CL_TRANSFER: begin
						ev[1]  = '{kind: KIND_FWD, value: rx_byte, last: 1'b0};
						ev_cnt = 2'd2;
					end
					CL_BREAK: begin
						rep_d  = 8'd0;
						pend_d = 8'd0;
						ev[1]  = '{kind: KIND_SINK_RST, value: 8'd0, last: 1'b0};
						ev_cnt = 2'd2;
					end
					CL_STATUS: begin
						if (((pend_q & STATUS_BUSY_MASK) != 8'd0) && hold_over)
							pend_d = pend_q & ~STATUS_BUSY_MASK;
					end
					default: begin
						phase_d = PH_SYNC1;
					end
				endcase
			end
			PH_COMP: begin
				phase_d = PH_LENLO;
				if (cmd_cls == CL_DATA) begin
					ev[0]  = '{kind: KIND_FWD, value: rx_byte, last: 1'b0};
					ev_cnt = 2'd1;
				end
			end
			PH_LENLO: begin
				len_d   = {8'd0, rx_byte};
				phase_d = PH_LENHI;
			end
			PH_LENHI: begin
				len_d   = len_full;
				count_d = 16'd0;
				phase_d = (len_full == 16'd0) ? PH_CK1 : PH_DATA;
				if (cmd_cls == CL_DATA && len_full == 16'd0)
					pend_d = pend_q | STATUS_FULL_MASK;
				if (cmd_cls == CL_DATA || cmd_cls == CL_TRANSFER || cmd_cls == CL_PRINT) begin
					ev[0]  = '{kind: KIND_FWD, value: len_q[7:0], last: 1'b0};
					ev[1]  = '{kind: KIND_FWD, value: rx_byte, last: 1'b0};
					ev_cnt = 2'd2;
				end
			end
			PH_DATA: begin
				count_d = count_inc;
				if (count_inc == len_q)
					phase_d = PH_CK1;
				ev[0]  = '{kind: KIND_FWD, value: rx_byte, last: 1'b0};
				ev_cnt = 2'd1;
				if (cmd_cls == CL_PRINT)
					commit_d = (count_inc == 16'd2) && (rx_byte == PRINT_END_BYTE);
				else
					commit_d = (cmd_cls == CL_TRANSFER);
			end
			PH_CK1: begin
				phase_d = PH_CK2;
			end
			PH_CK2: begin
				phase_d = PH_DEVID;
				reply   = cfg.device_id;
			end
			PH_DEVID: begin
				phase_d = PH_STATUS;
				reply   = rep_q;
			end
			PH_STATUS: begin
				phase_d = PH_SYNC1;
				if (commit_q) begin
					ev[0]    = '{kind: KIND_COMMIT, value: 8'd0, last: 1'b0};
					ev_cnt   = 2'd1;
					commit_d = 1'b0;
				end
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
	end

	// print command clears the timer, ticks count up and saturate
	always_comb begin
		timer_d = timer_q;
		if (step && phase_q == PH_CMD && byte_cls == CL_PRINT)
			timer_d = '0;
		else if (tick && timer_q != '1)
			timer_d = timer_q + TIMER_BITS'(1);
	end

	// events first, reply byte last
	always_comb begin
		bundle.cnt = ev_cnt + 2'd1;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < ev_cnt)
				bundle.item[i] = ev[i];
			else if (2'(i) == ev_cnt)
				bundle.item[i] = '{kind: KIND_REPLY, value: reply, last: 1'b1};
			else
				bundle.item[i] = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			cmd_q    <= 8'd0;
			rep_q    <= 8'd0;
			pend_q   <= 8'd0;
			len_q    <= 16'd0;
			count_q  <= 16'd0;
			commit_q <= 1'b0;
			timer_q  <= '0;
		end else begin
			timer_q <= timer_d;
			if (step) begin
				phase_q  <= phase_d;
				cmd_q    <= cmd_d;
				rep_q    <= rep_d;
				pend_q   <= pend_d;
				len_q    <= len_d;
				count_q  <= count_d;
				commit_q <= commit_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/printer_link_packet_receiver_top.sv =====
// Top level of the printer link packet receiver: input register, config
// registers, result buffer and output stream. Depends on plr_pkg, plr_core.
//
//  Channel   Signals                     Carries
//  s_axis    tvalid tready tdata tuser   link byte (tdata) / operation (tuser)
//  m_axis    tvalid tready tdata tuser   value (tdata), kind (tuser), last
//            tlast
//  cfg       cfg_wen cfg_index cfg_data  device id, transfer opcode, busy hold
//
// A link byte is held in the input register, then its 1 to 3 results
// drain from the result buffer at one per cycle while m_axis is ready.
// The next byte is loaded while the last result of the previous one is
// transferred. Reset is asynchronous, active low, and puts the receiver in
// sync hunting. A stalled output holds the buffer; ticks still pass.
`default_nettype none

module printer_link_packet_receiver_top #(
	parameter int unsigned TIMER_BITS = 24
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire  [7:0]                     s_axis_tdata,  // [7:0] rx_byte
	input  wire                            s_axis_tuser,  // [0] operation
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [7:0] value
	output logic [2:0]                     m_axis_tuser,  // [2:0] kind
	output logic                           m_axis_tlast,
	input  wire                            cfg_wen,
	input  wire  [plr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [plr_pkg::HOLD_W-1:0]     cfg_data
);
	import plr_pkg::*;

	logic          valid_s1;
	logic          op_s1;
	logic [7:0]    byte_s1;
	cfg_t          cfg_q;
	bundle_t       bundle;
	result_t [2:0] res_s2;
	logic [1:0]    n_q;
	logic [1:0]    pos_q;
	logic          buf_free;
	logic          advance;
	logic          out_take;
	logic          last_take;

	// handshake control
	assign out_take      = m_axis_tvalid && m_axis_tready;
	assign last_take     = out_take && ((pos_q + 2'd1) == n_q);
	assign buf_free      = (n_q == 2'd0) || last_take;
	assign advance       = valid_s1 && (op_s1 || buf_free);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id <= DEVICE_ID_RESET;
			cfg_q.xfer_opc  <= XFER_OPC_RESET;
			cfg_q.busy_hold <= BUSY_HOLD_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_DEVICE_ID: cfg_q.device_id <= cfg_data[7:0];
				CFG_XFER_OPC:  cfg_q.xfer_opc  <= cfg_data[7:0];
				CFG_BUSY_HOLD: cfg_q.busy_hold <= cfg_data;
				default: ;
			endcase
		end
	end

	plr_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && !op_s1),
		.tick   (advance && op_s1),
		.rx_byte(byte_s1),
		.cfg    (cfg_q),
		.bundle (bundle)
	);

	// result buffer: count and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= 2'd0;
			pos_q <= 2'd0;
		end else if (advance && !op_s1) begin
			n_q   <= bundle.cnt;
			pos_q <= 2'd0;
		end else if (last_take) begin
			n_q   <= 2'd0;
			pos_q <= 2'd0;
		end else if (out_take) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !op_s1)
			res_s2 <= bundle.item;
	end

	// output stream
	assign m_axis_tvalid = (n_q != 2'd0);
	assign m_axis_tdata  = res_s2[pos_q].value;
	assign m_axis_tuser  = res_s2[pos_q].kind;
	assign m_axis_tlast  = res_s2[pos_q].last;

	// read position stays inside the loaded results
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q != 2'd0) |-> (pos_q < n_q))
		else $error("result read position past loaded count");

	// the reply marked last is the final entry of the buffer
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == ((pos_q + 2'd1) == n_q)))
		else $error("last flag not on final result");

	// a new byte never overwrites results still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !op_s1 && n_q != 2'd0) |-> last_take)
		else $error("result buffer overwritten");

	// an empty buffer with no byte loading stays empty
	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q == 2'd0 && !(advance && !op_s1)) |=> (n_q == 2'd0))
		else $error("results appeared without a byte");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for printer_link_packet_receiver_top: drives link bytes and
// ticks on the input stream and scores every output transfer against a
// cycle-free model of the packet receiver. Depends on plr_pkg and the RTL.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import plr_pkg::*;

	// packet phases of the receiver model
	typedef enum logic [3:0] {
		HUNT_SYNC1, HUNT_SYNC2, GET_CMD, GET_COMP, GET_LEN_LO, GET_LEN_HI,
		GET_PAYLOAD, GET_CK1, GET_CK2, SEND_DEVID, SEND_STATUS
	} link_phase_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;   // [7:0] rx_byte
	logic                 s_axis_tuser;   // [0] operation
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [7:0]           m_axis_tdata;   // [7:0] value
	logic [2:0]           m_axis_tuser;   // [2:0] kind
	logic                 m_axis_tlast;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [HOLD_W-1:0]    cfg_data;

	printer_link_packet_receiver_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// register shadows
	logic [7:0]        dev_id    = DEVICE_ID_RESET;
	logic [7:0]        xfer_opc  = XFER_OPC_RESET;
	logic [HOLD_W-1:0] busy_hold = BUSY_HOLD_RESET;

	// receiver model state
	link_phase_t       link_phase   = HUNT_SYNC1;
	logic [7:0]        cur_cmd      = 8'h00;
	logic [7:0]        status_shown = 8'h00;
	logic [7:0]        status_next  = 8'h00;
	logic [15:0]       pay_len      = 16'h0000;
	logic [15:0]       pay_cnt      = 16'h0000;
	logic              commit_armed = 1'b0;
	logic [HOLD_W-1:0] ticks_since  = '0;

	result_t expected_results[$];
	int      mismatches = 0;
	int      sent_bytes = 0;
	bit      gaps_on  = 0;
	bit      stall_en = 0;
	bit      tick_mix = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// idle length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic cls_t cmd_class(input logic [7:0] c);
		cls_t r;
		case (c)
			CMD_INIT:   r = CL_INIT;
			CMD_PRINT:  r = CL_PRINT;
			CMD_DATA:   r = CL_DATA;
			CMD_BREAK:  r = CL_BREAK;
			CMD_STATUS: r = CL_STATUS;
			default:    r = (c == xfer_opc) ? CL_TRANSFER : CL_OTHER;
		endcase
		return r;
	endfunction

	function automatic void add_result(input kind_t k, input logic [7:0] v, input logic l);
		result_t e;
		e.kind  = k;
		e.value = v;
		e.last  = l;
		expected_results.push_back(e);
	endfunction

	// advance the receiver model by one accepted item
	function automatic void predict_link_item(input logic op, input logic [7:0] b);
		cls_t       cl;
		logic [7:0] reply;
		reply = 8'h00;
		if (op == OP_TICK) begin
			if (ticks_since != '1) ticks_since++;
			return;
		end
		case (link_phase)
			HUNT_SYNC1: begin
				commit_armed = 1'b0;
				link_phase = (b == SYNC1_BYTE) ? HUNT_SYNC2 : HUNT_SYNC1;
			end
			HUNT_SYNC2: link_phase = (b == SYNC2_BYTE) ? GET_CMD : HUNT_SYNC1;
			GET_CMD: begin
				cur_cmd = b;
				add_result(KIND_CMD, b, 1'b0);
				link_phase = GET_COMP;
				status_shown = status_next;
				cl = cmd_class(b);
				case (cl)
					CL_INIT: begin
						status_shown = 8'h00;
						status_next = 8'h00;
						add_result(KIND_FWD, b, 1'b0);
					end
					CL_PRINT: begin
						ticks_since = '0;
						if ((status_shown & STATUS_FULL_MASK) != 0)
							status_next |= STATUS_BUSY_MASK;
						add_result(KIND_FWD, b, 1'b0);
					end
					CL_DATA, CL_TRANSFER: add_result(KIND_FWD, b, 1'b0);
					CL_BREAK: begin
						add_result(KIND_SINK_RST, 8'h00, 1'b0);
						status_shown = 8'h00;
						status_next = 8'h00;
					end
					CL_STATUS: begin
						if ((status_shown & STATUS_BUSY_MASK) != 0 && ticks_since > busy_hold)
							status_next &= ~STATUS_BUSY_MASK;
					end
					default: link_phase = HUNT_SYNC1;
				endcase
			end
			GET_COMP: begin
				if (cmd_class(cur_cmd) == CL_DATA) add_result(KIND_FWD, b, 1'b0);
				link_phase = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				pay_len = {8'h00, b};
				link_phase = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				pay_len[15:8] = b;
				link_phase = (pay_len == 16'h0000) ? GET_CK1 : GET_PAYLOAD;
				cl = cmd_class(cur_cmd);
				if (cl == CL_DATA && pay_len == 16'h0000) status_next |= STATUS_FULL_MASK;
				if (cl == CL_DATA || cl == CL_TRANSFER || cl == CL_PRINT) begin
					add_result(KIND_FWD, pay_len[7:0], 1'b0);
					add_result(KIND_FWD, pay_len[15:8], 1'b0);
				end
				pay_cnt = 16'h0000;
			end
			GET_PAYLOAD: begin
				pay_cnt++;
				if (pay_cnt == pay_len) link_phase = GET_CK1;
				add_result(KIND_FWD, b, 1'b0);
				cl = cmd_class(cur_cmd);
				if (cl == CL_PRINT) commit_armed = (pay_cnt == 16'd2 && b == PRINT_END_BYTE);
				else commit_armed = (cl == CL_TRANSFER);
			end
			GET_CK1: link_phase = GET_CK2;
			GET_CK2: begin
				link_phase = SEND_DEVID;
				reply = dev_id;
			end
			SEND_DEVID: begin
				link_phase = SEND_STATUS;
				reply = status_shown;
			end
			SEND_STATUS: begin
				if (commit_armed) begin
					add_result(KIND_COMMIT, 8'h00, 1'b0);
					commit_armed = 1'b0;
				end
				link_phase = HUNT_SYNC1;
			end
			default: link_phase = HUNT_SYNC1;
		endcase
		add_result(KIND_REPLY, reply, 1'b1);
	endfunction

	// input transfers feed the model, output transfers are scored
	always @(posedge clk) begin : scoreboard
		result_t e;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			predict_link_item(s_axis_tuser, s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual kind %0d value %02h last %0b",
					$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
			end else begin
				e = expected_results.pop_front();
				if (m_axis_tuser != e.kind) begin
					mismatches++;
					$display("%0t: kind mismatch, expected %0d, actual %0d",
						$time, e.kind, m_axis_tuser);
				end
				if (m_axis_tdata != e.value) begin
					mismatches++;
					$display("%0t: value mismatch, expected %02h, actual %02h",
						$time, e.value, m_axis_tdata);
				end
				if (m_axis_tlast != e.last) begin
					mismatches++;
					$display("%0t: last mismatch, expected %0b, actual %0b",
						$time, e.last, m_axis_tlast);
				end
			end
		end
	end

	// result side backpressure
	initial begin : out_ready
		int hold_off;
		hold_off = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off--;
			end else begin
				m_axis_tready <= 1'b1;
				if (stall_en && $urandom_range(0, 3) == 0) hold_off = pick_gap();
			end
		end
	end

	// one input transfer, with an optional idle gap before it
	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_BYTE) sent_bytes++;
	endtask

	task automatic send_tick();
		send_item(OP_TICK, 8'($urandom));
	endtask

	// link byte, sometimes preceded by a tick
	task automatic send_byte(input logic [7:0] b);
		if (tick_mix && $urandom_range(0, 9) == 0) send_tick();
		send_item(OP_BYTE, b);
	endtask

	// complete packet; print_end puts the end marker in the second payload byte
	task automatic send_packet(input logic [7:0] cmd, input logic [7:0] comp,
			input logic [15:0] len, input bit print_end);
		send_byte(SYNC1_BYTE);
		send_byte(SYNC2_BYTE);
		send_byte(cmd);
		send_byte(comp);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (int i = 1; i <= len; i++)
			send_byte((print_end && i == 2) ? PRINT_END_BYTE : 8'($urandom));
		repeat (4) send_byte(8'($urandom)); // checksum, then the two reply slots
	endtask

	// wait until the receiver has nothing left to deliver
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HOLD_W-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_DEVICE_ID: dev_id = val[7:0];
			CFG_XFER_OPC:  xfer_opc = val[7:0];
			CFG_BUSY_HOLD: busy_hold = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// sync hunting: bad first and second sync bytes, ticks while hunting
	task automatic test_hunting();
		logic [7:0] seq [7];
		seq = '{8'h00, 8'hFF, SYNC1_BYTE, 8'h00, SYNC1_BYTE, SYNC1_BYTE, SYNC2_BYTE};
		foreach (seq[i]) send_byte(seq[i]);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_TICK, 8'h00);
	endtask

	// reset register values show in the replies
	task automatic test_defaults();
		send_packet(CMD_STATUS, 8'h00, 16'd0, 0);
		send_packet(XFER_OPC_RESET, 8'h00, 16'd1, 0);
	endtask

	// every fixed command and an unknown one, the print commit path, full and busy
	task automatic test_commands();
		send_packet(CMD_DATA, 8'h01, 16'd0, 0);   // empty data sets full
		send_packet(CMD_PRINT, 8'h00, 16'd2, 1);  // busy and a commit
		send_packet(CMD_DATA, 8'hFF, 16'd3, 0);
		send_packet(CMD_INIT, 8'h00, 16'd0, 0);
		send_packet(CMD_PRINT, 8'h00, 16'd3, 0);  // no end marker, no commit
		send_packet(CMD_BREAK, 8'h00, 16'd0, 0);
		send_packet(8'h55, 8'h00, 16'd0, 0);      // unknown command
		send_packet(CMD_STATUS, 8'h00, 16'd0, 0);
	endtask

	// busy clears only once the tick count exceeds the hold time
	task automatic test_busy_release();
		wait_idle();
		write_reg(CFG_BUSY_HOLD, 24'd3);
		send_packet(CMD_DATA, 8'h00, 16'd0, 0);
		send_packet(CMD_PRINT, 8'h00, 16'd2, 1);
		send_packet(CMD_STATUS, 8'h00, 16'd0, 0);
		repeat (3) send_tick();
		send_packet(CMD_STATUS, 8'h00, 16'd0, 0);
		send_tick();
		send_packet(CMD_STATUS, 8'h00, 16'd0, 0);
		send_packet(CMD_STATUS, 8'h00, 16'd0, 0);
	endtask

	// register extremes, transfer code shadowed by a fixed code
	task automatic test_register_extremes();
		logic [7:0] opcs [2];
		opcs = '{8'h00, CMD_DATA};
		foreach (opcs[i]) begin
			wait_idle();
			write_reg(CFG_DEVICE_ID, (i % 2 == 0) ? 24'h000000 : 24'h0000FF);
			write_reg(CFG_XFER_OPC, {16'h0000, opcs[i]});
			write_reg(CFG_BUSY_HOLD, (i % 2 == 0) ? 24'h000000 : 24'hFFFFFF);
			send_packet(opcs[i], 8'h01, 16'd2, 0);
			send_packet(CMD_DATA, 8'h00, 16'd0, 0);
			send_packet(CMD_PRINT, 8'h00, 16'd2, 1);
			send_tick();
			send_packet(CMD_STATUS, 8'h00, 16'd0, 0);
			send_packet(CMD_STATUS, 8'h00, 16'd0, 0);
		end
	endtask

	function automatic logic [7:0] pick_cmd();
		case ($urandom_range(0, 7))
			0: return CMD_INIT;
			1, 7: return CMD_PRINT;
			2: return CMD_DATA;
			3: return CMD_BREAK;
			4: return CMD_STATUS;
			5: return xfer_opc;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 16'($urandom_range(0, 3));
		if (r < 95) return 16'($urandom_range(4, 16));
		return 16'($urandom_range(17, 40));
	endfunction

	// truncated or corrupted packets; cut points never leave a length half read
	task automatic send_broken_packet();
		int m;
		case ($urandom_range(0, 2))
			0: send_byte(SYNC1_BYTE);
			1: begin
				send_byte(SYNC1_BYTE);
				send_byte(8'($urandom_range(0, 255)) ^ ((SYNC2_BYTE == 8'h33) ? 8'h00 : 8'h00));
			end
			default: begin
				m = $urandom_range(2, 10);
				send_byte(SYNC1_BYTE);
				send_byte(SYNC2_BYTE);
				send_byte(pick_cmd());
				send_byte(8'($urandom));
				send_byte(8'(m));
				send_byte(8'h00);
				repeat ($urandom_range(0, m - 1)) send_byte(8'($urandom));
			end
		endcase
	endtask

	task automatic randomize_registers();
		logic [7:0] opc;
		write_reg(CFG_DEVICE_ID, ($urandom_range(0, 3) == 0) ?
			24'($urandom_range(0, 1) * 255) : 24'($urandom_range(0, 255)));
		case ($urandom_range(0, 5))
			0: opc = CMD_DATA;
			1: opc = CMD_STATUS;
			2: opc = 8'h00;
			3: opc = 8'hFF;
			4: opc = XFER_OPC_RESET;
			default: begin
				opc = 8'($urandom);
				if (opc == SYNC1_BYTE) opc = 8'h42;
			end
		endcase
		write_reg(CFG_XFER_OPC, {16'h0000, opc});
		case ($urandom_range(0, 3))
			0: write_reg(CFG_BUSY_HOLD, 24'h000000);
			1: write_reg(CFG_BUSY_HOLD, 24'hFFFFFF);
			default: write_reg(CFG_BUSY_HOLD, 24'($urandom_range(1, 12)));
		endcase
	endtask

	// mostly well-formed packets with random content, plus noise and broken ones
	task automatic test_random_traffic();
		int target;
		int r;
		int section;
		target = sent_bytes + 120;
		section = 0;
		tick_mix = 1;
		while (sent_bytes < target) begin
			r = $urandom_range(0, 99);
			if (r < 72) send_packet(pick_cmd(), 8'($urandom), pick_len(),
				$urandom_range(0, 1));
			else if (r < 82) send_broken_packet();
			else if (r < 92) repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			else repeat ($urandom_range(1, 8)) send_tick();
			section++;
			if (section % 5 == 0) begin
				wait_idle();
				randomize_registers();
				gaps_on = ($urandom_range(0, 3) != 0);
				stall_en = ($urandom_range(0, 3) != 0);
			end else if (section % 3 == 0) begin
				wait_idle();
			end
		end
		tick_mix = 0;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = OP_BYTE;
		cfg_wen       = 1'b0;
		cfg_index     = CFG_DEVICE_ID;
		cfg_data      = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		gaps_on = 1;
		stall_en = 1;
		test_hunting();
		test_commands();
		test_busy_release();
		test_register_extremes();
		test_random_traffic();

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else begin
			if (expected_results.size() != 0)
				$display("%0t: %0d results expected, none arrived", $time,
					expected_results.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/plr_pkg.sv
sv/plr_core.sv
sv/printer_link_packet_receiver_top.sv
bench/tb.sv
